/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define FTK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// checked during reset as well
`define FTK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define FTK_ASSERT(lbl, clk, rst_n, prop)
`define FTK_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/ftk_pkg.sv */
`default_nettype none

package ftk_pkg;

    localparam int MAX_KEEP    = 16;
    localparam int IDX_W       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int FILL_W      = $clog2(MAX_KEEP + 1);
    localparam int KEEP_W      = 5;
    localparam int CAP_W       = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;
    localparam int NODE_W      = 32;
    localparam int SCORE_W     = 64;
    localparam int DIV_CNT_W   = $clog2(SCORE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUCCESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT  = 2'd2;

    typedef struct packed {
        logic               op;
        logic [NODE_W-1:0]  node_first;
        logic [NODE_W-1:0]  node_second;
        logic [SCORE_W-1:0] raw_count;
        logic [SCORE_W-1:0] success_count;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]  pair_first;
        logic [NODE_W-1:0]  pair_second;
        logic [SCORE_W-1:0] score;
        logic               was_empty;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [SCORE_W-1:0] divisor;
        logic [SCORE_W-1:0] min_success;
        logic [KEEP_W-1:0]  keep_count;
    } t_cfg;

    typedef struct packed {
        logic [NODE_W-1:0]  node_first;
        logic [NODE_W-1:0]  node_second;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic   is_drain;
        t_entry ent;
    } t_job;

endpackage

`default_nettype wire

/* hw/rtl/ftk_front.sv */
`default_nettype none

`include "assert_macros.svh"

module ftk_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire ftk_pkg::t_in_item i_item,
    input  wire ftk_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output ftk_pkg::t_job        o_job
);

    logic                             accept;
    logic                             qualify;
    logic                             r_active;
    logic [ftk_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [ftk_pkg::SCORE_W-1:0]      r_q;
    logic [ftk_pkg::SCORE_W-1:0]      r_rem;
    logic [ftk_pkg::NODE_W-1:0]       r_first;
    logic [ftk_pkg::NODE_W-1:0]       r_second;
    logic [ftk_pkg::SCORE_W:0]        rem_sh;
    logic [ftk_pkg::SCORE_W:0]        diff;
    logic                             ge;
    logic [ftk_pkg::SCORE_W-1:0]      n_q;
    logic [ftk_pkg::SCORE_W-1:0]      n_rem;
    logic                             div_done;

    assign o_busy  = r_active | i_q_full;
    assign accept  = i_start && !o_busy;
    assign qualify = (i_item.success_count >= i_cfg.min_success)
                     && (i_cfg.keep_count != '0);

    // one quotient bit per cycle, restoring
    assign rem_sh   = {r_rem, r_q[ftk_pkg::SCORE_W-1]};
    assign diff     = rem_sh - {1'b0, i_cfg.divisor};
    assign ge       = !diff[ftk_pkg::SCORE_W];
    assign n_rem    = ge ? diff[ftk_pkg::SCORE_W-1:0] : rem_sh[ftk_pkg::SCORE_W-1:0];
    assign n_q      = {r_q[ftk_pkg::SCORE_W-2:0], ge};
    assign div_done = r_active && (r_cnt == '0);

    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        if (div_done) begin
            o_push                 = 1'b1;
            o_job.is_drain         = 1'b0;
            o_job.ent.node_first   = r_first;
            o_job.ent.node_second  = r_second;
            o_job.ent.score        = n_q;
        end else if (accept && (i_item.op == ftk_pkg::OP_DRAIN)) begin
            o_push         = 1'b1;
            o_job.is_drain = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (div_done) begin
            r_active <= 1'b0;
        end else if (accept && (i_item.op == ftk_pkg::OP_OFFER) && qualify) begin
            r_active <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q      <= i_item.raw_count;
            r_rem    <= '0;
            r_cnt    <= ftk_pkg::DIV_CNT_W'(ftk_pkg::SCORE_W - 1);
            r_first  <= i_item.node_first;
            r_second <= i_item.node_second;
        end else if (r_active) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - ftk_pkg::DIV_CNT_W'(1);
        end
    end

    `FTK_ASSERT(a_push_room, i_clk, i_rst_n, o_push |-> !i_q_full)
    `FTK_ASSERT(a_rem_below_div, i_clk, i_rst_n, r_active |-> (r_rem < i_cfg.divisor))

endmodule

`default_nettype wire

/* hw/rtl/ftk_queue.sv */
`default_nettype none

`include "assert_macros.svh"

module ftk_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ftk_pkg::t_job i_job,
    input  wire logic          i_pop,
    output ftk_pkg::t_job      o_head,
    output logic               o_empty,
    output logic               o_full
);

    ftk_pkg::t_job                 r_mem [ftk_pkg::QUEUE_DEPTH];
    logic [ftk_pkg::QPTR_W-1:0]    r_wr;
    logic [ftk_pkg::QPTR_W-1:0]    r_rd;
    logic [ftk_pkg::QCNT_W-1:0]    r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == ftk_pkg::QCNT_W'(ftk_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == ftk_pkg::QPTR_W'(ftk_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_wr + ftk_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == ftk_pkg::QPTR_W'(ftk_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_rd + ftk_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + ftk_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - ftk_pkg::QCNT_W'(1);
            end
        end
    end

    `FTK_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> !o_empty)

endmodule

`default_nettype wire

/* hw/rtl/ftk_back.sv */
`default_nettype none

`include "assert_macros.svh"

module ftk_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ftk_pkg::KEEP_W-1:0]  i_keep_count,
    input  wire ftk_pkg::t_job               i_head,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    output logic                             o_res_valid,
    output ftk_pkg::t_out_item               o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]                      r_state;
    logic [ftk_pkg::FILL_W-1:0]      r_fill;
    logic [ftk_pkg::FILL_W-1:0]      r_n;
    logic [ftk_pkg::IDX_W-1:0]       r_idx;
    logic [ftk_pkg::IDX_W-1:0]       r_pos;
    ftk_pkg::t_entry                 r_best;
    ftk_pkg::t_job                   r_job;
    ftk_pkg::t_entry                 r_tab [ftk_pkg::MAX_KEEP];
    ftk_pkg::t_entry                 nb    [ftk_pkg::MAX_KEEP];
    logic                            r_res_valid;
    ftk_pkg::t_out_item              r_res;

    logic [ftk_pkg::CAP_W-1:0]       kc_ext;
    logic [ftk_pkg::CAP_W-1:0]       max_ext;
    logic [ftk_pkg::FILL_W-1:0]      cap;
    logic                            take;
    logic                            do_insert;
    ftk_pkg::t_entry                 cur;
    logic                            better;
    logic                            scan_end;
    logic                            apply;
    logic                            remove;
    logic                            put_last;

    assign kc_ext  = ftk_pkg::CAP_W'(i_keep_count);
    assign max_ext = ftk_pkg::CAP_W'(ftk_pkg::MAX_KEEP);
    assign cap     = (kc_ext > max_ext) ? ftk_pkg::FILL_W'(max_ext)
                                        : ftk_pkg::FILL_W'(kc_ext);

    assign take      = (r_state == ST_IDLE) && !i_empty;
    assign o_pop     = take;
    assign do_insert = take && !i_head.is_drain && (r_fill < cap);

    // running minimum, strict compare keeps the earliest of equal scores
    assign cur      = r_tab[r_idx];
    assign better   = (r_idx == '0) || (cur.score < r_best.score);
    assign scan_end = ((ftk_pkg::FILL_W'(r_idx) + ftk_pkg::FILL_W'(1)) == r_n);

    assign apply    = (r_state == ST_APPLY);
    assign remove   = apply && (r_job.is_drain || (r_job.ent.score > r_best.score));
    assign put_last = remove && !r_job.is_drain;

    genvar g;
    generate
        for (g = 0; g < ftk_pkg::MAX_KEEP; g++) begin : g_nb
            if (g < ftk_pkg::MAX_KEEP - 1) begin : g_mid
                assign nb[g] = r_tab[g+1];
            end else begin : g_top
                assign nb[g] = r_tab[g];
            end
        end
    endgenerate

    // table kept in insertion order, removal closes the gap
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ftk_pkg::MAX_KEEP; i++) begin
            if (do_insert && (r_fill[ftk_pkg::IDX_W-1:0] == ftk_pkg::IDX_W'(i))) begin
                r_tab[i] <= i_head.ent;
            end else if (remove) begin
                if ((ftk_pkg::IDX_W'(i) >= r_pos)
                    && (ftk_pkg::FILL_W'(i + 1) < r_n)) begin
                    r_tab[i] <= nb[i];
                end
                if (put_last && (ftk_pkg::FILL_W'(i + 1) == r_n)) begin
                    r_tab[i] <= r_job.ent;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        if (i_head.is_drain) begin
                            if (r_fill == '0) begin
                                r_res_valid <= 1'b1;
                            end else begin
                                r_n     <= r_fill;
                                r_idx   <= '0;
                                r_state <= ST_SCAN;
                            end
                        end else if (do_insert) begin
                            r_fill <= r_fill + ftk_pkg::FILL_W'(1);
                        end else if (r_fill != '0) begin
                            r_n     <= r_fill;
                            r_idx   <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + ftk_pkg::IDX_W'(1);
                    if (scan_end) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (r_job.is_drain) begin
                        r_res_valid <= 1'b1;
                        r_n         <= r_n - ftk_pkg::FILL_W'(1);
                        r_idx       <= '0;
                        if (r_n == ftk_pkg::FILL_W'(1)) begin
                            r_fill  <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_head;
        end
        if ((r_state == ST_SCAN) && better) begin
            r_best <= cur;
            r_pos  <= r_idx;
        end
        if (take && i_head.is_drain) begin
            r_res <= '{pair_first: '0, pair_second: '0, score: '0,
                       was_empty: 1'b1, last: 1'b1};
        end else if (apply) begin
            r_res <= '{pair_first: r_best.node_first, pair_second: r_best.node_second,
                       score: r_best.score, was_empty: 1'b0,
                       last: (r_n == ftk_pkg::FILL_W'(1))};
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `FTK_ASSERT(a_scan_nonempty, i_clk, i_rst_n, (r_state != ST_IDLE) |-> (r_n != '0))
    `FTK_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= ftk_pkg::FILL_W'(ftk_pkg::MAX_KEEP))

endmodule

`default_nettype wire

/* hw/rtl/filtered_top_k_selector.sv */
// offer: taken while busy is low; a qualifying one then holds busy while the bit-serial
//   divider forms raw_count / divisor, so no other item is taken meanwhile; a filtered
//   one leaves busy low; a full table has its minimum replaced by a higher new score
// drain: taken once busy is low, i.e. the queue has room and no division runs; each
//   kept entry needs a minimum scan over the entries left, results one per strobe
// results cannot be stalled; synchronous active-low reset empties the table at once
`default_nettype none

`include "assert_macros.svh"

module filtered_top_k_selector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire ftk_pkg::t_in_item                 i_item,
    output logic                                   o_res_valid,
    output ftk_pkg::t_out_item                     o_res,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ftk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ftk_pkg::SCORE_W-1:0]       i_cfg_data
);

    ftk_pkg::t_cfg  r_cfg;
    ftk_pkg::t_job  push_job;
    ftk_pkg::t_job  head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.divisor     <= ftk_pkg::SCORE_W'(1);
            r_cfg.min_success <= '0;
            r_cfg.keep_count  <= ftk_pkg::KEEP_W'(16);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                ftk_pkg::CFG_DIVISOR: begin
                    // a zero divisor is dropped
                    if (i_cfg_data != '0) begin
                        r_cfg.divisor <= i_cfg_data;
                    end
                end
                ftk_pkg::CFG_MIN_SUCCESS: begin
                    r_cfg.min_success <= i_cfg_data;
                end
                ftk_pkg::CFG_KEEP_COUNT: begin
                    r_cfg.keep_count <= i_cfg_data[ftk_pkg::KEEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ftk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    ftk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ftk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keep_count (r_cfg.keep_count),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res)
    );

    `FTK_ASSERT(a_divisor_nonzero, i_clk, i_rst_n, r_cfg.divisor != '0)

endmodule

`default_nettype wire
